// ===== hdl/assert_macros.svh =====
// assertion helpers used by the lexer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, quiet during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// clocked implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/stl_pkg.sv =====
package stl_pkg;

   localparam int PosBits  = 16;
   localparam int LookDepth = 6;
   localparam int FillBits = $clog2(LookDepth + 1);
   localparam int QueueDepth = 2;
   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
   localparam logic [15:0] CntMax = 16'hffff;

   typedef enum logic [3:0] {
      KIND_PUNCT   = 4'd0,
      KIND_INT     = 4'd1,
      KIND_FLOAT   = 4'd2,
      KIND_STRING  = 4'd3,
      KIND_BOOL    = 4'd4,
      KIND_KEYWORD = 4'd5,
      KIND_NAME    = 4'd6,
      KIND_UNKNOWN = 4'd7,
      KIND_NOQUOTE = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NUMBER = 4'b0010,
      MODE_STRING = 4'b0100,
      MODE_NAME   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  detail;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] recorded_length;
      logic [15:0] value_start;
      logic [15:0] value_length;
      logic        run_end;
   } rsp_type;

   // one queued character with its class bits precomputed by the front end
   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
      logic       is_digit;
      logic       is_letter;
      logic       is_punct;
      logic       is_op;
      logic       is_space;
      logic       is_newline;
      logic       is_quote;
   } chr_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == CntMax) ? v : v + 16'd1;
   endfunction

   // keyword table: true false def ext return do end else
   function automatic logic [7:0] word_byte(input logic [2:0] w, input logic [2:0] i);
      logic [47:0] s;
      case (w)
         3'd0: s = {"true", 16'h0};
         3'd1: s = {"false", 8'h0};
         3'd2: s = {"def", 24'h0};
         3'd3: s = {"ext", 24'h0};
         3'd4: s = "return";
         3'd5: s = {"do", 32'h0};
         3'd6: s = {"end", 24'h0};
         default: s = {"else", 16'h0};
      endcase
      word_byte = s[47 - 8*i -: 8];
   endfunction

   function automatic logic [2:0] word_len(input logic [2:0] w);
      case (w)
         3'd0: word_len = 3'd4;
         3'd1: word_len = 3'd5;
         3'd2: word_len = 3'd3;
         3'd3: word_len = 3'd3;
         3'd4: word_len = 3'd6;
         3'd5: word_len = 3'd2;
         3'd6: word_len = 3'd3;
         default: word_len = 3'd4;
      endcase
   endfunction

endpackage

// ===== hdl/stl_front.sv =====
module stl_front
   import stl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_ready,
   output chr_type q_data
);

   chr_type q_mem_ff [QueueDepth];
   logic [$clog2(QueueDepth)-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [$clog2(QueueDepth+1)-1:0] count_ff;
   chr_type cls;
   logic push, pop;

   // classify the incoming character
   always_comb begin
      cls.ch = req_data.ch;
      cls.last_char = req_data.last_char;
      cls.is_digit = req_data.ch >= "0" && req_data.ch <= "9";
      cls.is_letter = (req_data.ch >= "a" && req_data.ch <= "z") ||
                      (req_data.ch >= "A" && req_data.ch <= "Z") || req_data.ch == "_";
      cls.is_punct = req_data.ch == "." || req_data.ch == "," || req_data.ch == "|" ||
                     req_data.ch == "(" || req_data.ch == ")";
      cls.is_op = req_data.ch == "+" || req_data.ch == "-" || req_data.ch == "/" ||
                  req_data.ch == "*" || req_data.ch == "%" || req_data.ch == "^" ||
                  req_data.ch == "=";
      cls.is_space = req_data.ch == " ";
      cls.is_newline = req_data.ch == 8'h0a || req_data.ch == 8'h0d;
      cls.is_quote = req_data.ch == 8'h27;
   end

   assign req_ready = count_ff != QueueDepth[$clog2(QueueDepth+1)-1:0];
   assign push = req_valid && req_ready;
   assign q_valid = count_ff != '0;
   assign pop = q_valid && q_ready;
   assign q_data = q_mem_ff[rd_ptr_ff];

   // request queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + {{($clog2(QueueDepth+1)-1){1'b0}}, push}
                     - {{($clog2(QueueDepth+1)-1){1'b0}}, pop};
      end
   end

endmodule

// ===== hdl/stl_back.sv =====
module stl_back
   import stl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_ready,
   input  chr_type q_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
`include "assert_macros.svh"

   // lexer state
   logic [PosBits-1:0] position_ff, position_in;
   logic [15:0] line_ff, line_in, column_ff, column_in;
   chr_type win_ff [LookDepth];
   chr_type win_in [LookDepth];
   logic [FillBits-1:0] fill_ff, fill_in;
   mode_type mode_ff, mode_in;
   logic [PosBits-1:0] tstart_ff, tstart_in;
   logic [15:0] tlen_ff, tlen_in;
   logic isint_ff, isint_in;
   logic halted_ff, halted_in;
   logic atend_ff, atend_in;
   logic out_valid_ff;
   rsp_type out_ff, out_in;

   // word scan results
   logic [2:0] word_hit;
   logic word_found, word_wait;

   logic can_step, load, emit, stall, finish;
   logic [2:0] n_cons;
   logic adv_col;
   chr_type c0, c1;

   // the back end makes one decision a cycle while its output is free or taken;
   // it loads a character only on a stall with no end-of-script flush pending
   assign can_step = !out_valid_ff || rsp_ready;

   // keyword scan over the window, first match wins
   always_comb begin
      logic done;
      logic st_ok, st_wait;
      word_hit = 3'd0;
      word_found = 1'b0;
      word_wait = 1'b0;
      done = 1'b0;
      for (int w = 0; w < 8; w++) begin
         st_ok = 1'b1;
         st_wait = 1'b0;
         for (int i = 0; i < 6; i++) begin
            if (i < word_len(3'(w)) && st_ok && !st_wait) begin
               if (FillBits'(i) >= fill_ff) begin
                  if (atend_ff) st_ok = 1'b0;
                  else st_wait = 1'b1;
               end else if (win_ff[i].ch != word_byte(3'(w), 3'(i))) begin
                  st_ok = 1'b0;
               end
            end
         end
         if (!done) begin
            if (st_wait) begin
               word_wait = 1'b1;
               done = 1'b1;
            end else if (st_ok) begin
               word_found = 1'b1;
               word_hit = 3'(w);
               done = 1'b1;
            end
         end
      end
   end

   assign c0 = win_ff[0];
   assign c1 = win_ff[1];

   // one lexer step
   always_comb begin
      logic [15:0] col_after;
      logic [PosBits-1:0] pos_after;
      position_in = position_ff;
      line_in = line_ff;
      column_in = column_ff;
      fill_in = fill_ff;
      mode_in = mode_ff;
      tstart_in = tstart_ff;
      tlen_in = tlen_ff;
      isint_in = isint_ff;
      halted_in = halted_ff;
      atend_in = atend_ff;
      out_in = out_ff;
      for (int i = 0; i < LookDepth; i++) win_in[i] = win_ff[i];
      n_cons = 3'd0;
      adv_col = 1'b1;
      emit = 1'b0;
      load = 1'b0;
      stall = 1'b0;
      finish = 1'b0;
      q_ready = 1'b0;
      out_in.run_end = 1'b0;
      out_in.detail = 8'd0;
      out_in.line = line_ff;

      if (can_step) begin
         if (halted_ff) begin
            // drop characters until the script ends
            q_ready = 1'b1;
            if (q_valid && q_data.last_char) finish = 1'b1;
         end else begin
            case (mode_ff)
               MODE_NUMBER: begin
                  if (fill_ff == '0) begin
                     if (atend_ff) begin
                        emit = 1'b1;
                        out_in.kind = isint_ff ? KIND_INT : KIND_FLOAT;
                        out_in.column = column_ff;
                        out_in.recorded_length = 16'd0;
                        out_in.value_start = 16'(tstart_ff);
                        out_in.value_length = tlen_ff;
                        mode_in = MODE_IDLE;
                     end else stall = 1'b1;
                  end else if (c0.is_digit) begin
                     n_cons = 3'd1;
                     tlen_in = sat_inc(tlen_ff);
                  end else if (c0.ch == "." && isint_ff && fill_ff >= FillBits'(2)
                               && c1.is_digit) begin
                     n_cons = 3'd1;
                     tlen_in = sat_inc(tlen_ff);
                     isint_in = 1'b0;
                  end else if (c0.ch == "." && isint_ff && fill_ff < FillBits'(2)
                               && !atend_ff) begin
                     stall = 1'b1;
                  end else begin
                     emit = 1'b1;
                     out_in.kind = isint_ff ? KIND_INT : KIND_FLOAT;
                     out_in.column = column_ff;
                     out_in.recorded_length = 16'd0;
                     out_in.value_start = 16'(tstart_ff);
                     out_in.value_length = tlen_ff;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_STRING: begin
                  if (fill_ff == '0) begin
                     if (atend_ff) begin
                        emit = 1'b1;
                        out_in.kind = KIND_NOQUOTE;
                        out_in.column = (tlen_ff == 16'd0) ? sat_inc(column_ff) : column_ff;
                        out_in.recorded_length = 16'd0;
                        out_in.value_start = 16'(tstart_ff);
                        out_in.value_length = tlen_ff;
                        halted_in = 1'b1;
                     end else stall = 1'b1;
                  end else begin
                     n_cons = 3'd1;
                     if (c0.is_quote) begin
                        emit = 1'b1;
                        out_in.kind = KIND_STRING;
                        out_in.column = sat_inc(column_ff);
                        out_in.recorded_length = tlen_ff;
                        out_in.value_start = 16'(tstart_ff);
                        out_in.value_length = tlen_ff;
                        mode_in = MODE_IDLE;
                     end else tlen_in = sat_inc(tlen_ff);
                  end
               end
               MODE_NAME: begin
                  if (fill_ff == '0) begin
                     if (atend_ff) begin
                        emit = 1'b1;
                        out_in.kind = KIND_NAME;
                        out_in.column = column_ff;
                        out_in.recorded_length = tlen_ff;
                        out_in.value_start = 16'(tstart_ff);
                        out_in.value_length = tlen_ff;
                        mode_in = MODE_IDLE;
                     end else stall = 1'b1;
                  end else if (c0.is_letter) begin
                     n_cons = 3'd1;
                     tlen_in = sat_inc(tlen_ff);
                  end else begin
                     emit = 1'b1;
                     out_in.kind = KIND_NAME;
                     out_in.column = column_ff;
                     out_in.recorded_length = tlen_ff;
                     out_in.value_start = 16'(tstart_ff);
                     out_in.value_length = tlen_ff;
                     mode_in = MODE_IDLE;
                  end
               end
               default: begin
                  if (fill_ff == '0) stall = 1'b1;
                  else if (c0.is_space) n_cons = 3'd1;
                  else if (c0.is_newline) begin
                     n_cons = 3'd1;
                     adv_col = 1'b0;
                  end else if (c0.is_punct) begin
                     emit = 1'b1;
                     out_in.kind = KIND_PUNCT;
                     out_in.detail = c0.ch;
                     out_in.column = column_ff;
                     out_in.recorded_length = 16'd1;
                     out_in.value_start = 16'(position_ff);
                     out_in.value_length = 16'd0;
                     n_cons = 3'd1;
                  end else if (c0.is_digit) begin
                     tstart_in = position_ff;
                     tlen_in = 16'd1;
                     isint_in = 1'b1;
                     n_cons = 3'd1;
                     mode_in = MODE_NUMBER;
                  end else if (c0.is_quote) begin
                     n_cons = 3'd1;
                     tstart_in = (position_ff == PosMax) ? position_ff
                                 : position_ff + PosBits'(1);
                     tlen_in = 16'd0;
                     mode_in = MODE_STRING;
                  end else if (word_wait) begin
                     stall = 1'b1;
                  end else if (word_found) begin
                     n_cons = word_len(word_hit);
                     emit = 1'b1;
                     out_in.value_start = 16'(position_ff);
                     out_in.recorded_length = 16'(word_len(word_hit));
                     if (word_hit < 3'd2) begin
                        out_in.kind = KIND_BOOL;
                        out_in.detail = (word_hit == 3'd0) ? 8'd1 : 8'd0;
                        out_in.value_length = 16'(word_len(word_hit));
                     end else begin
                        out_in.kind = KIND_KEYWORD;
                        out_in.detail = 8'(word_hit - 3'd2);
                        out_in.value_length = 16'd0;
                     end
                  end else if (c0.is_op) begin
                     emit = 1'b1;
                     out_in.kind = KIND_NAME;
                     out_in.detail = c0.ch;
                     out_in.column = column_ff;
                     out_in.recorded_length = 16'd1;
                     out_in.value_start = 16'(position_ff);
                     out_in.value_length = 16'd1;
                     n_cons = 3'd1;
                  end else if (c0.is_letter) begin
                     tstart_in = position_ff;
                     tlen_in = 16'd1;
                     n_cons = 3'd1;
                     mode_in = MODE_NAME;
                  end else begin
                     emit = 1'b1;
                     out_in.kind = KIND_UNKNOWN;
                     out_in.detail = c0.ch;
                     out_in.column = column_ff;
                     out_in.recorded_length = 16'd0;
                     out_in.value_start = 16'(position_ff);
                     out_in.value_length = 16'd1;
                     halted_in = 1'b1;
                  end
               end
            endcase

            // resolved with nothing left: end of script resets everything
            if (stall && atend_ff) finish = 1'b1;
            // a stalled window takes the next character
            if (stall && !atend_ff) begin
               q_ready = 1'b1;
               load = q_valid;
            end
            if (halted_in && atend_ff) finish = 1'b1;
         end
      end

      // apply consumption
      pos_after = position_ff;
      col_after = column_ff;
      for (int k = 0; k < 6; k++) begin
         if (3'(k) < n_cons) begin
            if (pos_after != PosMax) pos_after = pos_after + PosBits'(1);
            if (adv_col) col_after = sat_inc(col_after);
         end
      end
      if (n_cons != 3'd0) begin
         position_in = pos_after;
         column_in = col_after;
         if (!adv_col) begin
            line_in = sat_inc(line_ff);
            column_in = 16'd1;
         end
         // shift the window down by the consumed count
         for (int i = 0; i < LookDepth; i++) begin
            for (int k = 1; k <= LookDepth; k++) begin
               if (i + k < LookDepth && n_cons == 3'(k)) win_in[i] = win_ff[i + k];
            end
         end
         fill_in = fill_ff - FillBits'(n_cons);
      end
      if (emit && mode_ff != MODE_IDLE && mode_ff != MODE_STRING) out_in.column = column_ff;
      if (emit && word_found && mode_ff == MODE_IDLE && !c0.is_punct && !c0.is_digit
          && !c0.is_quote && !c0.is_space && !c0.is_newline && fill_ff != '0)
         out_in.column = col_after;
      if (emit && mode_ff == MODE_STRING && fill_ff != '0) out_in.column = col_after;

      // load a character into the window
      if (load) begin
         if (fill_ff < FillBits'(LookDepth)) begin
            win_in[fill_ff[$clog2(LookDepth)-1:0]] = q_data;
            fill_in = fill_ff + FillBits'(1);
         end
         atend_in = q_data.last_char;
      end

      // run_end: this token ends the step if nothing further can emit before
      // the next load; computed by lookahead is costly, so mark at stall time

      if (finish) begin
         position_in = '0;
         line_in = 16'd1;
         column_in = 16'd1;
         fill_in = '0;
         mode_in = MODE_IDLE;
         tstart_in = '0;
         tlen_in = 16'd0;
         isint_in = 1'b1;
         halted_in = 1'b0;
         atend_in = 1'b0;
      end
   end

   // a token is held back until the next token or the step end, so its run_end
   // can be set once the step is known to have no more output
   logic held_ff, held_in;
   rsp_type held_tok_ff, held_tok_in;
   logic step_done;
   logic push_out;
   rsp_type push_tok;

   // the step is over once the window stalls, flushes or the lexer is halted
   assign step_done = can_step && (stall || finish || halted_ff);

   // output stage: pushes the held token when the next token or step end arrives
   assign push_out = held_ff && (emit || step_done) && can_step;

   always_comb begin
      held_in = held_ff;
      held_tok_in = held_tok_ff;
      if (push_out) held_in = 1'b0;
      if (emit) begin
         held_in = 1'b1;
         held_tok_in = out_in;
      end
   end

   always_comb begin
      push_tok = held_tok_ff;
      push_tok.run_end = !emit;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LookDepth; i++) win_ff[i] <= win_in[i];
      if (emit) held_tok_ff <= held_tok_in;
      if (push_out) out_ff <= push_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         line_ff <= 16'd1;
         column_ff <= 16'd1;
         fill_ff <= '0;
         mode_ff <= MODE_IDLE;
         tstart_ff <= '0;
         tlen_ff <= 16'd0;
         isint_ff <= 1'b1;
         halted_ff <= 1'b0;
         atend_ff <= 1'b0;
         held_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         position_ff <= position_in;
         line_ff <= line_in;
         column_ff <= column_in;
         fill_ff <= fill_in;
         mode_ff <= mode_in;
         tstart_ff <= tstart_in;
         tlen_ff <= tlen_in;
         isint_ff <= isint_in;
         halted_ff <= halted_in;
         atend_ff <= atend_in;
         held_ff <= held_in;
         out_valid_ff <= push_out ? 1'b1 : (out_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   `ASSERT_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= FillBits'(LookDepth), "window overfilled")
   `ASSERT_IMPLY(a_halt_idle, clock, reset, halted_ff, !emit, "token while halted")
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

endmodule

// ===== hdl/script_token_lexer_top.sv =====
// path: a request passes the front-end queue, the back-end window and the held-token
//   register to the output register; later tokens follow one per cycle while rsp_ready
// flow: the back end takes a new character into its window only when a decision
//   stalls for more input; other decisions consume, emit or flush from the window
// reset: synchronous, active high; clears position, line, column, window and mode
// the end-of-script character also returns all lexer state to its reset values
module script_token_lexer_top
   import stl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    q_valid, q_ready;
   chr_type q_data;

   // front end: accept and classify
   stl_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   // back end: tokenize
   stl_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
